// ===== sv/umed_pkg.sv =====
// Shared types, code index names and lookup functions for the USB-MIDI event decoder.
// No dependencies; the classifier, the top level and the testbench import this package.
package umed_pkg;

  localparam logic [3:0] CIN_MISC       = 4'h0;
  localparam logic [3:0] CIN_CABLE      = 4'h1;
  localparam logic [3:0] CIN_SYS_COM2   = 4'h2;
  localparam logic [3:0] CIN_SYS_COM3   = 4'h3;
  localparam logic [3:0] CIN_SX_START   = 4'h4;
  localparam logic [3:0] CIN_SX_END1    = 4'h5;
  localparam logic [3:0] CIN_SX_END2    = 4'h6;
  localparam logic [3:0] CIN_SX_END3    = 4'h7;
  localparam logic [3:0] CIN_NOTE_OFF   = 4'h8;
  localparam logic [3:0] CIN_NOTE_ON    = 4'h9;
  localparam logic [3:0] CIN_POLY_PRESS = 4'hA;
  localparam logic [3:0] CIN_CTRL       = 4'hB;
  localparam logic [3:0] CIN_PROG       = 4'hC;
  localparam logic [3:0] CIN_CHAN_PRESS = 4'hD;
  localparam logic [3:0] CIN_PITCH      = 4'hE;
  localparam logic [3:0] CIN_SINGLE     = 4'hF;

  typedef enum logic [2:0] {
    CLS_IGNORE,
    CLS_PASS,
    CLS_SX_CONT,
    CLS_SX_END,
    CLS_COMMON_END
  } cls_e;

  typedef struct packed {
    logic [1:0] count;
    logic       sysex;
  } decode_t;

  function automatic cls_e code_class(input logic [3:0] code);
    cls_e cls;
    unique case (code) inside
      CIN_MISC, CIN_CABLE:       cls = CLS_IGNORE;
      CIN_SX_START:              cls = CLS_SX_CONT;
      CIN_SX_END1:               cls = CLS_COMMON_END;
      CIN_SX_END2, CIN_SX_END3:  cls = CLS_SX_END;
      default:                   cls = CLS_PASS;
    endcase
    return cls;
  endfunction

  function automatic logic [1:0] code_count(input logic [3:0] code);
    logic [1:0] cnt;
    unique case (code) inside
      CIN_MISC, CIN_CABLE:                             cnt = 2'd0;
      CIN_SX_END1, CIN_SINGLE:                         cnt = 2'd1;
      CIN_SYS_COM2, CIN_SX_END2, CIN_PROG, CIN_CHAN_PRESS: cnt = 2'd2;
      CIN_SYS_COM3, CIN_SX_START, CIN_SX_END3, CIN_NOTE_OFF, CIN_NOTE_ON,
      CIN_POLY_PRESS, CIN_CTRL, CIN_PITCH:             cnt = 2'd3;
      default:                                         cnt = 2'd0;
    endcase
    return cnt;
  endfunction

endpackage

// ===== sv/umed_in_if.sv =====
// Handshake interface that carries one USB-MIDI event packet per word.
// No dependencies.
interface umed_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] event_packet;

  modport source (output valid, output event_packet, input ready);
  modport sink (input valid, input event_packet, output ready);
endinterface

// ===== sv/umed_out_if.sv =====
// Handshake interface that carries one tagged MIDI byte per word.
// No dependencies.
interface umed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;
  logic       is_sysex;
  logic       last_byte;

  modport source (output valid, output midi_byte, output is_sysex, output last_byte,
                  input ready);
  modport sink (input valid, input midi_byte, input is_sysex, input last_byte,
                output ready);
endinterface

// ===== sv/umed_classify.sv =====
// Header classifier: byte count and path tag per packet, plus the per-cable SysEx flags.
// Depends on umed_pkg.
module umed_classify (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          header_i,
  output umed_pkg::decode_t   dec_o
);
  import umed_pkg::*;

  logic [15:0] flags_q, flags_d;
  logic [3:0]  code;
  logic [3:0]  cable;
  cls_e        cls;
  logic        flag_next;
  logic        flag_write;

  assign code  = header_i[3:0];
  assign cable = header_i[7:4];
  assign cls   = code_class(code);

  always_comb begin
    dec_o.count = code_count(code);
    dec_o.sysex = 1'b0;
    flag_next   = 1'b0;
    flag_write  = 1'b1;
    unique case (cls)
      CLS_PASS: begin
        dec_o.sysex = 1'b0;
      end
      CLS_SX_CONT: begin
        dec_o.sysex = 1'b1;
        flag_next   = 1'b1;
      end
      CLS_SX_END: begin
        dec_o.sysex = 1'b1;
      end
      CLS_COMMON_END: begin
        dec_o.sysex = flags_q[cable];
      end
      default: begin
        flag_write = 1'b0;
      end
    endcase
  end

  always_comb begin
    flags_d = flags_q;
    if (accept_i && flag_write) begin
      flags_d[cable] = flag_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  // A SysEx start packet leaves its cable in SysEx.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && code == CIN_SX_START |=> flags_q[$past(cable)])
    else $error("SysEx flag not set after start packet");

  // An ignored packet never changes any flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (code == CIN_MISC || code == CIN_CABLE) |=> flags_q == $past(flags_q))
    else $error("ignored packet changed SysEx flags");

  // A normal-path packet takes its cable out of SysEx.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && cls == CLS_PASS |=> !flags_q[$past(cable)])
    else $error("SysEx flag not cleared by normal packet");

endmodule

// ===== sv/usb_midi_event_decoder.sv =====
// Top level of the USB-MIDI event decoder: packet buffer and byte output register.
// Depends on umed_pkg, umed_in_if, umed_out_if and umed_classify.
//
//   channel  dir  word                                   handshake
//   evt_i    in   event_packet[31:0]                     valid/ready
//   byte_o   out  midi_byte[7:0], is_sysex, last_byte    valid/ready
//
// A packet is classified in the cycle it is accepted and its bytes enter a buffer.
// One byte per cycle moves from the buffer to the output register while the output is not
// stalled; a packet holds one to three bytes, and ignored packets put none in the buffer.
// The first byte goes through the buffer and then the output register. The single output
// port sets the rate.
// Reset clears the buffer count, the output valid and all SysEx flags.
// A stalled output holds its word; the buffer accepts a new packet as its last byte leaves.
module usb_midi_event_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  umed_in_if.sink     evt_i,
  umed_out_if.source  byte_o
);
  import umed_pkg::*;

  logic [23:0] data_q, data_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        sx_q, sx_d;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic        out_sx_q;
  logic        last_q;
  logic        out_load;
  logic        take;
  logic        accept;
  decode_t     dec;

  assign out_load    = !out_valid_q || byte_o.ready;
  assign take        = out_load && (cnt_q != 2'd0);
  assign evt_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_load);
  assign accept      = evt_i.valid && evt_i.ready;

  umed_classify u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .header_i (evt_i.event_packet[7:0]),
    .dec_o    (dec)
  );

  always_comb begin
    data_d = data_q;
    cnt_d  = cnt_q;
    sx_d   = sx_q;
    if (accept) begin
      data_d = evt_i.event_packet[31:8];
      cnt_d  = dec.count;
      sx_d   = dec.sysex;
    end else if (take) begin
      data_d = {8'h00, data_q[23:8]};
      cnt_d  = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (out_load) begin
        out_valid_q <= take;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    sx_q   <= sx_d;
    if (take) begin
      byte_q   <= data_q[7:0];
      out_sx_q <= sx_q;
      last_q   <= (cnt_q == 2'd1);
    end
  end

  assign byte_o.valid     = out_valid_q;
  assign byte_o.midi_byte = byte_q;
  assign byte_o.is_sysex  = out_sx_q;
  assign byte_o.last_byte = last_q;

  // The input side only stalls while the buffer still holds bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !evt_i.ready |-> cnt_q != 2'd0)
    else $error("input stalled with empty buffer");

  // The final buffered byte is shown marked as last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && cnt_q == 2'd1 |=> byte_o.valid && byte_o.last_byte)
    else $error("final byte not marked last");

  // An accepted ignored packet leaves nothing in the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (evt_i.event_packet[3:0] == CIN_MISC || evt_i.event_packet[3:0] == CIN_CABLE)
      |=> cnt_q == 2'd0)
    else $error("ignored packet produced bytes");

endmodule

// ===== test/tb.sv =====
// Testbench for usb_midi_event_decoder: directed and random USB-MIDI packets with a scoreboard.
// Depends on umed_pkg, umed_in_if, umed_out_if and the decoder RTL.
// A local decoder model predicts every output word, including per-cable SysEx tracking.
`timescale 1ns / 100ps

module tb;
  import umed_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 8;

  typedef struct packed {
    logic [7:0] midi_byte;
    logic       is_sysex;
    logic       last_byte;
  } midi_word_t;

  logic clk_i;
  logic rst_ni;

  umed_in_if  evt_if ();
  umed_out_if byte_if ();

  usb_midi_event_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .byte_o (byte_if)
  );

  midi_word_t  pending_words[$];
  logic        sysex_open[16];
  bit          idle_on;
  int unsigned n_errors;
  int unsigned n_packets;
  int unsigned n_ignored;
  int unsigned n_bytes;
  int unsigned n_sysex_bytes;
  int unsigned n_decoded;
  int unsigned stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic cls_e packet_class(input logic [3:0] code);
    case (code)
      CIN_MISC, CIN_CABLE:      return CLS_IGNORE;
      CIN_SX_START:             return CLS_SX_CONT;
      CIN_SX_END1:              return CLS_COMMON_END;
      CIN_SX_END2, CIN_SX_END3: return CLS_SX_END;
      default:                  return CLS_PASS;
    endcase
  endfunction

  function automatic int unsigned packet_length(input logic [3:0] code);
    case (code)
      CIN_MISC, CIN_CABLE:                                  return 0;
      CIN_SX_END1, CIN_SINGLE:                              return 1;
      CIN_SYS_COM2, CIN_SX_END2, CIN_PROG, CIN_CHAN_PRESS: return 2;
      default:                                              return 3;
    endcase
  endfunction

  function automatic logic [31:0] make_packet(input logic [3:0] cable, input logic [3:0] code,
                                              input logic [23:0] data);
    return {data, cable, code};
  endfunction

  task automatic queue_expected_bytes(input logic [31:0] pkt);
    logic [3:0]  code;
    logic [3:0]  cable;
    cls_e        cls;
    int unsigned len;
    logic        sx;
    midi_word_t  w;
    code  = pkt[3:0];
    cable = pkt[7:4];
    cls   = packet_class(code);
    len   = packet_length(code);
    sx    = 1'b0;
    n_packets++;
    case (cls)
      CLS_PASS: begin
        sysex_open[cable] = 1'b0;
      end
      CLS_SX_CONT: begin
        sysex_open[cable] = 1'b1;
        sx = 1'b1;
      end
      CLS_SX_END: begin
        sysex_open[cable] = 1'b0;
        sx = 1'b1;
      end
      CLS_COMMON_END: begin
        sx = sysex_open[cable];
        sysex_open[cable] = 1'b0;
      end
      default: begin
        len = 0;
      end
    endcase
    if (cls == CLS_IGNORE) begin
      n_ignored++;
    end else begin
      n_decoded++;
    end
    for (int unsigned k = 0; k < len; k++) begin
      w.midi_byte = pkt[8*(k+1) +: 8];
      w.is_sysex  = sx;
      w.last_byte = (k + 1 == len);
      pending_words.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  task automatic send_packet(input logic [31:0] pkt);
    evt_if.valid        <= 1'b1;
    evt_if.event_packet <= pkt;
    do @(posedge clk_i); while (!evt_if.ready);
    queue_expected_bytes(pkt);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic hold_off_until_drained();
    evt_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  task automatic send_sysex_stream(input logic [3:0] cable);
    repeat ($urandom_range(0, 4)) send_packet(make_packet(cable, CIN_SX_START, 24'($urandom)));
    case ($urandom_range(0, 4))
      0: send_packet(make_packet(cable, CIN_SX_END1, 24'($urandom)));
      1: send_packet(make_packet(cable, CIN_SX_END2, 24'($urandom)));
      2: send_packet(make_packet(cable, CIN_SX_END3, 24'($urandom)));
      3: send_packet(make_packet(cable, 4'($urandom_range(CIN_NOTE_OFF, CIN_SINGLE)),
                                 24'($urandom)));
      default: begin
      end
    endcase
  endtask

  task automatic send_mixed_traffic(input int unsigned n_items);
    int unsigned goal;
    logic [3:0]  cable;
    goal = n_decoded + n_items;
    while (n_decoded < goal) begin
      cable = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_sysex_stream(cable);
        6, 7: send_packet(make_packet(cable, 4'($urandom_range(CIN_NOTE_OFF, CIN_SINGLE)),
                                      24'($urandom)));
        8: begin
          case ($urandom_range(0, 2))
            0:       send_packet(make_packet(cable, CIN_SYS_COM2, 24'($urandom)));
            1:       send_packet(make_packet(cable, CIN_SYS_COM3, 24'($urandom)));
            default: send_packet(make_packet(cable, CIN_SX_END1, 24'($urandom)));
          endcase
        end
        default: send_packet($urandom);
      endcase
    end
  endtask

  task automatic test_code_table();
    logic [23:0] data;
    for (int c = 0; c < 16; c++) begin
      case (c % 4)
        0:       data = 24'hFFFFFF;
        1:       data = 24'h000000;
        2:       data = 24'h7F80FF;
        default: data = 24'h80017F;
      endcase
      send_packet(make_packet(4'(c) ^ 4'hF, 4'(c), data));
    end
  endtask

  task automatic test_sysex_tracking();
    send_packet(make_packet(4'd2, CIN_SX_END1, 24'h0000F1));
    send_packet(make_packet(4'd2, CIN_SX_START, 24'h0102F0));
    send_packet(make_packet(4'd2, CIN_SX_END1, 24'hAAAAF7));
    send_packet(make_packet(4'd2, CIN_SX_START, 24'h7F7FF0));
    send_packet(make_packet(4'd3, CIN_SX_END1, 24'h5555F6));
    send_packet(make_packet(4'd2, CIN_CABLE, 24'hFFFFFF));
    send_packet(make_packet(4'd2, CIN_SX_END1, 24'h1234F7));
    send_packet(make_packet(4'd15, CIN_SX_START, 24'h0000F0));
    send_packet(make_packet(4'd15, CIN_NOTE_ON, 24'h7F3C90));
    send_packet(make_packet(4'd15, CIN_SX_END1, 24'hFFFFF8));
  endtask

  task automatic test_random_traffic();
    send_mixed_traffic(340);
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      send_mixed_traffic(12);
      hold_off_until_drained();
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    send_mixed_traffic(80);
  endtask

  initial begin
    rst_ni              = 1'b0;
    evt_if.valid        = 1'b0;
    evt_if.event_packet = '0;
    idle_on             = 1'b1;
    n_errors            = 0;
    n_packets           = 0;
    n_ignored           = 0;
    n_bytes             = 0;
    n_sysex_bytes       = 0;
    n_decoded           = 0;
    for (int c = 0; c < 16; c++) sysex_open[c] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_code_table();
    test_sysex_tracking();
    test_random_traffic();
    test_drain_pause();
    test_back_to_back();

    hold_off_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Run covered %0d packets (%0d ignored) across all code indexes and cables,",
             n_packets, n_ignored);
    $display("with %0d output words checked, %0d of them on the SysEx path.",
             n_bytes, n_sysex_bytes);
    if (n_errors == 0) begin
      $display("** usb_midi_event_decoder: PASSED **");
    end else begin
      $display("** usb_midi_event_decoder: FAILED **");
    end
    $finish;
  end

  initial begin
    byte_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        byte_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      byte_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    midi_word_t w;
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      n_bytes++;
      if (byte_if.is_sysex === 1'b1) n_sysex_bytes++;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %02h sysex=%b last=%b",
                                  byte_if.midi_byte, byte_if.is_sysex, byte_if.last_byte));
      end else begin
        w = pending_words.pop_front();
        if (byte_if.midi_byte !== w.midi_byte)
          report_mismatch($sformatf("midi_byte %02h, expected %02h",
                                    byte_if.midi_byte, w.midi_byte));
        if (byte_if.is_sysex !== w.is_sysex)
          report_mismatch($sformatf("is_sysex %b, expected %b on byte %02h",
                                    byte_if.is_sysex, w.is_sysex, w.midi_byte));
        if (byte_if.last_byte !== w.last_byte)
          report_mismatch($sformatf("last_byte %b, expected %b on byte %02h",
                                    byte_if.last_byte, w.last_byte, w.midi_byte));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (evt_if.valid && evt_if.ready) || (byte_if.valid && byte_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d words still pending.",
               STALL_LIMIT, pending_words.size());
      $display("** usb_midi_event_decoder: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
